// File: hw/rtl/qau_pkg.sv
// qau_pkg: shared types and codes of the quaternion arithmetic unit
// no dependencies
`default_nettype none

package qau_pkg;

  // action codes on the input channel
  typedef enum logic [2:0] {
    ACT_MULTIPLY  = 3'd0,
    ACT_MUL_VEC   = 3'd1,
    ACT_SCALE     = 3'd2,
    ACT_LENGTH    = 3'd3,
    ACT_NORMALIZE = 3'd4,
    ACT_INVERT    = 3'd5
  } action_e;

  // class of work handed from the front to the back
  typedef enum logic [1:0] {
    OP_PRODUCT = 2'd0,
    OP_LENGTH  = 2'd1,
    OP_NORM    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef struct packed {
    op_e  op;
    logic conj;
  } ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/qau_if.sv
// qau_in_if, qau_out_if: valid/ready channels of the quaternion unit
// no dependencies
`default_nettype none

interface qau_in_if #(
  parameter int CB = 16
);
  logic          valid;
  logic          ready;
  logic [2:0]    action;
  logic [CB-1:0] a_w;
  logic [CB-1:0] a_x;
  logic [CB-1:0] a_y;
  logic [CB-1:0] a_z;
  logic [CB-1:0] b_w;
  logic [CB-1:0] b_x;
  logic [CB-1:0] b_y;
  logic [CB-1:0] b_z;
  logic [CB-1:0] scale_value;

  modport source (output valid, action, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  scale_value, input ready);
  modport sink (input valid, action, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                scale_value, output ready);
endinterface

interface qau_out_if #(
  parameter int CB = 16
);
  logic          valid;
  logic          ready;
  logic [CB-1:0] res_w;
  logic [CB-1:0] res_x;
  logic [CB-1:0] res_y;
  logic [CB-1:0] res_z;
  logic [CB-1:0] magnitude;
  logic          overflow;
  logic          zero_length;

  modport source (output valid, res_w, res_x, res_y, res_z, magnitude, overflow,
                  zero_length, input ready);
  modport sink (input valid, res_w, res_x, res_y, res_z, magnitude, overflow,
                zero_length, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qau_front.sv
// qau_front: accepts items and classifies the action into work for the back
// depends on qau_pkg, qau_if
`default_nettype none

module qau_front #(
  parameter int CB = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  qau_in_if.sink               in_i,
  output qau_pkg::ctrl_t       ctrl_o,
  output logic [7:0][CB-1:0]   comp_o,
  output logic                 valid_o,
  input  wire logic            ready_i
);

  logic               valid_q;
  qau_pkg::ctrl_t     ctrl_q, ctrl_d;
  logic [7:0][CB-1:0] comp_q, comp_d;
  logic               take;

  assign in_i.ready = !valid_q || ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    ctrl_d.op   = qau_pkg::OP_PRODUCT;
    ctrl_d.conj = 1'b0;
    comp_d      = {in_i.b_z, in_i.b_y, in_i.b_x, in_i.b_w,
                   in_i.a_z, in_i.a_y, in_i.a_x, in_i.a_w};
    case (in_i.action)
      qau_pkg::ACT_MULTIPLY: ;
      // pure vector: scalar part of b forced to zero
      qau_pkg::ACT_MUL_VEC: comp_d[4] = '0;
      // scaling is a product with (s, 0, 0, 0)
      qau_pkg::ACT_SCALE: comp_d[7:4] = {{(3*CB){1'b0}}, in_i.scale_value};
      qau_pkg::ACT_LENGTH: ctrl_d.op = qau_pkg::OP_LENGTH;
      qau_pkg::ACT_NORMALIZE: ctrl_d.op = qau_pkg::OP_NORM;
      qau_pkg::ACT_INVERT: begin
        ctrl_d.op   = qau_pkg::OP_NORM;
        ctrl_d.conj = 1'b1;
      end
      default: ctrl_d.op = qau_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ctrl_q <= ctrl_d;
      comp_q <= comp_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign comp_o  = comp_q;

endmodule

`default_nettype wire

// File: hw/rtl/qau_fifo.sv
// qau_fifo: short queue between the front and the back
// no dependencies
`default_nettype none

module qau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign ready_o = (cnt_q != CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qau_back.sv
// qau_back: execution pipeline (products, square root, division, output register)
// depends on qau_pkg, qau_if
`default_nettype none

module qau_back #(
  parameter int CB = 16,
  parameter int FB = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire qau_pkg::ctrl_t    ctrl_i,
  input  wire logic [7:0][CB-1:0] comp_i,
  qau_out_if.source              out_o
);

  localparam int NSQ = CB + 1;          // root bits
  localparam int RW  = NSQ + 3;         // sqrt remainder
  localparam int LB  = CB + 2;          // rounded length
  localparam int QB  = FB + 1;          // quotient bits
  localparam int NB  = CB + FB + 1;     // dividend
  localparam int WW  = 2 * CB + FB + 4; // wide signed work width
  localparam logic signed [WW-1:0] SMAX = WW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] SMIN = -SMAX - WW'(1);
  localparam logic signed [WW-1:0] HALF = WW'(64'sd1 <<< (FB - 1));

  typedef struct packed {
    qau_pkg::ctrl_t     ctrl;
    logic [3:0][CB-1:0] res;
    logic               ov;
    logic [3:0][CB-1:0] mag_a;
    logic [3:0]         neg;
    logic [LB-1:0]      len;
  } car_t;

  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [NSQ-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [3:0][LB-1:0] rem;
    logic [3:0][QB-1:0] quo;
    logic [3:0][NB-1:0] num;
  } dv_t;

  logic adv;
  assign adv     = !out_o.valid || out_o.ready;
  assign ready_o = adv;

  // stage 0: products and squares
  logic                 v0_q;
  qau_pkg::ctrl_t       c0_q;
  logic signed [2*CB-1:0] prod_q [4][4];
  logic [2*CB-1:0]      sqr_q [4];
  logic [3:0][CB-1:0]   mag0_q;
  logic [3:0]           neg0_q;
  logic signed [CB-1:0] av [4];
  logic signed [CB-1:0] bv [4];
  logic [CB-1:0]        am [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      av[i] = $signed(comp_i[i]);
      bv[i] = $signed(comp_i[4+i]);
      am[i] = av[i][CB-1] ? CB'(-av[i]) : CB'(av[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c0_q <= ctrl_i;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[i][j] <= av[i] * bv[j];
        end
        sqr_q[i]  <= am[i] * am[i];
        mag0_q[i] <= am[i];
        // conjugate flips the vector part
        neg0_q[i] <= av[i][CB-1] ^ (ctrl_i.conj && (i != 0));
      end
    end
  end

  // stage 1: Hamilton sums, rounding, saturation, sum of squares
  logic signed [WW-1:0] hs [4];
  logic signed [WW-1:0] hr [4];
  car_t                 c1;
  logic [2*NSQ-1:0]     ssum;

  always_comb begin
    hs[0] = WW'(prod_q[0][0]) - WW'(prod_q[1][1]) - WW'(prod_q[2][2]) - WW'(prod_q[3][3]);
    hs[1] = WW'(prod_q[0][1]) + WW'(prod_q[1][0]) + WW'(prod_q[2][3]) - WW'(prod_q[3][2]);
    hs[2] = WW'(prod_q[0][2]) - WW'(prod_q[1][3]) + WW'(prod_q[2][0]) + WW'(prod_q[3][1]);
    hs[3] = WW'(prod_q[0][3]) + WW'(prod_q[1][2]) - WW'(prod_q[2][1]) + WW'(prod_q[3][0]);
    c1       = '0;
    c1.ctrl  = c0_q;
    c1.mag_a = mag0_q;
    c1.neg   = neg0_q;
    for (int i = 0; i < 4; i++) begin
      hr[i] = (hs[i] + HALF) >>> FB;
      if (c0_q.op == qau_pkg::OP_PRODUCT) begin
        if (hr[i] > SMAX) begin
          c1.res[i] = SMAX[CB-1:0];
          c1.ov     = 1'b1;
        end else if (hr[i] < SMIN) begin
          c1.res[i] = SMIN[CB-1:0];
          c1.ov     = 1'b1;
        end else begin
          c1.res[i] = hr[i][CB-1:0];
        end
      end
    end
    ssum = (2*NSQ)'(sqr_q[0]) + (2*NSQ)'(sqr_q[1]) + (2*NSQ)'(sqr_q[2])
         + (2*NSQ)'(sqr_q[3]);
  end

  // square root: one root bit per stage
  logic             vs_q  [NSQ+1];
  car_t             cs_q  [NSQ+1];
  sq_t              sq_q  [NSQ+1];
  logic [2*NSQ-1:0] ss_q  [NSQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      vs_q[0] <= 1'b0;
    end else if (adv) begin
      v0_q  <= valid_i;
      vs_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cs_q[0] <= c1;
      sq_q[0] <= '0;
      ss_q[0] <= ssum;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    sq_t           nx;
    logic [RW-1:0] rn, tr;
    always_comb begin
      rn = {sq_q[k].rem[RW-3:0], ss_q[k][2*(NSQ-1-k)+1 -: 2]};
      tr = {1'b0, sq_q[k].root, 2'b01};
      if (rn >= tr) begin
        nx.rem  = rn - tr;
        nx.root = {sq_q[k].root[NSQ-2:0], 1'b1};
      end else begin
        nx.rem  = rn;
        nx.root = {sq_q[k].root[NSQ-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else if (adv) begin
        vs_q[k+1] <= vs_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k+1] <= nx;
        cs_q[k+1] <= cs_q[k];
        ss_q[k+1] <= ss_q[k];
      end
    end
  end

  // length rounding
  logic vl_q;
  car_t cl_q, cl_d;

  always_comb begin
    cl_d     = cs_q[NSQ];
    cl_d.len = LB'(sq_q[NSQ].root)
             + LB'(sq_q[NSQ].rem > RW'(sq_q[NSQ].root));
  end

  // dividend set-up: |v| * 2^FB + len / 2
  logic vd_q [QB+1];
  car_t cd_q [QB+1];
  dv_t  dv_q [QB+1];
  dv_t  dv0;

  always_comb begin
    dv0 = '0;
    for (int i = 0; i < 4; i++) begin
      dv0.num[i] = (NB'(cl_q.mag_a[i]) << FB) + NB'(cl_q.len >> 1);
      dv0.rem[i] = LB'(dv0.num[i][NB-1:QB]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q    <= 1'b0;
      vd_q[0] <= 1'b0;
    end else if (adv) begin
      vl_q    <= vs_q[NSQ];
      vd_q[0] <= vl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cl_q    <= cl_d;
      cd_q[0] <= cl_q;
      dv_q[0] <= dv0;
    end
  end

  // restoring division, four lanes, one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    dv_t           nx;
    logic [LB:0]   r2 [4];
    logic [LB:0]   dd;
    always_comb begin
      nx = dv_q[j];
      dd = {1'b0, cd_q[j].len};
      for (int i = 0; i < 4; i++) begin
        r2[i] = {dv_q[j].rem[i], dv_q[j].num[i][QB-1-j]};
        if (r2[i] >= dd) begin
          nx.rem[i] = LB'(r2[i] - dd);
          nx.quo[i] = {dv_q[j].quo[i][QB-2:0], 1'b1};
        end else begin
          nx.rem[i] = LB'(r2[i]);
          nx.quo[i] = {dv_q[j].quo[i][QB-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[j+1] <= 1'b0;
      end else if (adv) begin
        vd_q[j+1] <= vd_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[j+1] <= nx;
        cd_q[j+1] <= cd_q[j];
      end
    end
  end

  // result selection and output register
  car_t                 cf;
  logic [3:0][CB-1:0]   res_d;
  logic [CB-1:0]        mag_d;
  logic                 ov_d, zl_d, len_big;
  logic signed [WW-1:0] qv;

  always_comb begin
    cf      = cd_q[QB];
    len_big = (cf.len[LB-1:CB] != '0);
    mag_d   = len_big ? '1 : cf.len[CB-1:0];
    res_d   = '0;
    ov_d    = 1'b0;
    zl_d    = 1'b0;
    qv      = '0;
    case (cf.ctrl.op)
      qau_pkg::OP_PRODUCT: begin
        res_d = cf.res;
        ov_d  = cf.ov;
      end
      qau_pkg::OP_LENGTH: ov_d = len_big;
      qau_pkg::OP_NORM: begin
        // zero length means a is all zeros, so the result stays zero
        zl_d = (cf.len == '0);
        if (!zl_d) begin
          for (int i = 0; i < 4; i++) begin
            qv = cf.neg[i] ? -WW'(dv_q[QB].quo[i]) : WW'(dv_q[QB].quo[i]);
            if (qv > SMAX) begin
              res_d[i] = SMAX[CB-1:0];
              ov_d     = 1'b1;
            end else if (qv < SMIN) begin
              res_d[i] = SMIN[CB-1:0];
              ov_d     = 1'b1;
            end else begin
              res_d[i] = qv[CB-1:0];
            end
          end
        end
      end
      default: mag_d = '0;
    endcase
  end

  logic               ovld_q;
  logic [3:0][CB-1:0] ores_q;
  logic [CB-1:0]      omag_q;
  logic               oov_q, ozl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (adv) begin
      ovld_q <= vd_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ores_q <= res_d;
      omag_q <= mag_d;
      oov_q  <= ov_d;
      ozl_q  <= zl_d;
    end
  end

  assign out_o.valid       = ovld_q;
  assign out_o.res_w       = ores_q[0];
  assign out_o.res_x       = ores_q[1];
  assign out_o.res_y       = ores_q[2];
  assign out_o.res_z       = ores_q[3];
  assign out_o.magnitude   = omag_q;
  assign out_o.overflow    = oov_q;
  assign out_o.zero_length = ozl_q;

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_arithmetic_unit.sv
// quaternion_arithmetic_unit: top level of the fixed-point quaternion unit
// depends on qau_pkg, qau_if, qau_front, qau_fifo, qau_back
// throughput: one item per cycle whenever the result side takes one per cycle
// reset: asynchronous, active low; clears all valid flags, no clearing pass
`default_nettype none

module quaternion_arithmetic_unit #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 12
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  qau_in_if.sink      in_i,
  qau_out_if.source   out_o
);

  localparam int CB    = COMPONENT_BITS;
  localparam int QW    = $bits(qau_pkg::ctrl_t) + 8 * CB;

  // front: input register and action decode
  qau_pkg::ctrl_t     f_ctrl;
  logic [7:0][CB-1:0] f_comp;
  logic               f_valid, f_ready;

  qau_front #(.CB(CB)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .ctrl_o  (f_ctrl),
    .comp_o  (f_comp),
    .valid_o (f_valid),
    .ready_i (f_ready)
  );

  // two-entry queue lets front and back stall on their own
  logic [QW-1:0]      q_data;
  logic               q_valid, q_ready;
  qau_pkg::ctrl_t     b_ctrl;
  logic [7:0][CB-1:0] b_comp;

  qau_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .data_i  ({f_ctrl, f_comp}),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .data_o  (q_data)
  );

  assign {b_ctrl, b_comp} = q_data;

  // back: products, length, division and the output register
  qau_back #(.CB(CB), .FB(FRACTION_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ready_o (q_ready),
    .ctrl_i  (b_ctrl),
    .comp_i  (b_comp),
    .out_o   (out_o)
  );

  // a zero length only ever comes from an all-zero quaternion
  a_zl_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_length |->
      out_o.res_w == '0 && out_o.res_x == '0 && out_o.res_y == '0 && out_o.res_z == '0)
    else $error("zero length with non-zero result");

  a_zl_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_length |-> out_o.magnitude == '0)
    else $error("zero length with non-zero magnitude");

  a_zl_ov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_length |-> !out_o.overflow)
    else $error("zero length together with overflow");

endmodule

`default_nettype wire
